FILE: rtl/gjr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GJR-GARCH generator package
// Shared types and constants of the intraday return generator.
// ----------------------------------------------------------------------------
package gjr_pkg;

    localparam int MaxSlots = 4096;

    typedef enum logic [2:0] {
        CFG_ARCH    = 3'd0,
        CFG_PERSIST = 3'd1,
        CFG_ASYM    = 3'd2,
        CFG_H0      = 3'd3,
        CFG_SLOTS   = 3'd4
    } t_cfg_idx;

    // Request and status between the sequencer and the serial arithmetic unit.
    typedef enum logic [2:0] {
        OP_MUL  = 3'd1,
        OP_DIV  = 3'd2,
        OP_SQRT = 3'd4
    } t_op;

    typedef struct packed {
        logic        start;
        t_op         op;
        logic [63:0] a;
        logic [31:0] b;
    } t_su_req;

    typedef struct packed {
        logic        done;
        logic [63:0] res;
    } t_su_rsp;

endpackage

FILE: rtl/gjr_garch_intraday_return_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GJR-GARCH intraday return generator
// Turns each innovation beat into an intraday return and reports daily
// return, variance and realized variance at the end of each day.
// ----------------------------------------------------------------------------
// One beat is processed at a time by a sequencer around a single bit-serial
// arithmetic unit that delivers one result bit per cycle. An ordinary slot
// runs a 32-step multiply for the return and one for its square. The first
// slot of a day adds a 64-step divide and a 32-step square root, and the last
// slot adds three multiplies for the variance update. The result register lets
// the next beat be accepted while the previous result waits.
module gjr_garch_intraday_return_generator
    import gjr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_innovation,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_intraday_return,
    output logic        o_day_end,
    output logic [31:0] o_daily_return,
    output logic [31:0] o_daily_variance,
    output logic [31:0] o_realized_variance
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_DIV   = 11'b00000000010,
        S_SQRT  = 11'b00000000100,
        S_RMUL  = 11'b00000001000,
        S_SQMUL = 11'b00000010000,
        S_ACC   = 11'b00000100000,
        S_R2    = 11'b00001000000,
        S_CMUL  = 11'b00010000000,
        S_BMUL  = 11'b00100000000,
        S_HMUL  = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    logic [15:0] r_arch, r_persist, r_asym;
    logic [31:0] r_h0;
    logic [12:0] r_slots;

    logic [31:0] r_hvar, r_scale, r_rsum, r_sqsum;
    logic [11:0] r_slot;
    logic        r_first;

    logic [15:0] r_z;
    logic [31:0] r_ret;
    logic        r_last;
    logic signed [40:0] r_hacc;

    logic        r_ovalid;
    logic [31:0] r_o_ret, r_o_dret, r_o_dvar, r_o_rv;
    logic        r_o_end;

    t_su_req su_req;
    t_su_rsp su_rsp;

    logic [12:0] eff_n;
    logic [15:0] zmag;
    logic [31:0] rmag, smag;
    logic        can_out;

    gjr_serial_unit u_su (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (su_req),
        .o_rsp  (su_rsp)
    );

    always_comb begin
        if (r_slots == 13'd0) begin
            eff_n = 13'd1;
        end else if (r_slots > 13'(MaxSlots)) begin
            eff_n = 13'(MaxSlots);
        end else begin
            eff_n = r_slots;
        end
    end

    assign zmag    = r_z[15] ? 16'(-r_z) : r_z;
    assign rmag    = r_ret[31] ? 32'(-r_ret) : r_ret;
    assign smag    = r_rsum[31] ? 32'(-r_rsum) : r_rsum;
    assign can_out = !r_ovalid || i_ready;
    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        su_req.start = 1'b0;
        su_req.op    = OP_MUL;
        su_req.a     = '0;
        su_req.b     = '0;
        n_state      = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (r_slot == 12'd0) begin
                        su_req.start = 1'b1;
                        su_req.op    = OP_DIV;
                        su_req.a     = {8'd0, (r_first ? r_h0 : r_hvar), 24'd0};
                        su_req.b     = {19'd0, eff_n};
                        n_state      = S_DIV;
                    end else begin
                        su_req.start = 1'b1;
                        su_req.a     = {48'd0, (i_innovation[15] ? 16'(-i_innovation)
                                                              : i_innovation)};
                        su_req.b     = r_scale;
                        n_state      = S_RMUL;
                    end
                end
            end
            S_DIV: begin
                if (su_rsp.done) begin
                    su_req.start = 1'b1;
                    su_req.op    = OP_SQRT;
                    su_req.a     = su_rsp.res;
                    n_state      = S_SQRT;
                end
            end
            S_SQRT: begin
                if (su_rsp.done) begin
                    su_req.start = 1'b1;
                    su_req.a     = {48'd0, zmag};
                    su_req.b     = su_rsp.res[31:0];
                    n_state      = S_RMUL;
                end
            end
            S_RMUL: begin
                if (su_rsp.done) begin
                    n_state = S_SQMUL;
                end
            end
            S_SQMUL: begin
                su_req.start = 1'b1;
                su_req.a     = {32'd0, rmag};
                su_req.b     = rmag;
                n_state      = S_ACC;
            end
            S_ACC: begin
                if (su_rsp.done) begin
                    n_state = r_last ? S_R2 : S_OUT;
                end
            end
            S_R2: begin
                su_req.start = 1'b1;
                su_req.a     = {32'd0, smag};
                su_req.b     = smag;
                n_state      = S_CMUL;
            end
            S_CMUL: begin
                if (su_rsp.done) begin
                    su_req.start = 1'b1;
                    su_req.a     = {24'd0, su_rsp.res[63:24]};
                    su_req.b     = {15'd0, ({1'b0, r_arch}
                                   + (r_rsum[31] ? {1'b0, r_asym} : 17'd0))};
                    n_state      = S_BMUL;
                end
            end
            S_BMUL: begin
                if (su_rsp.done) begin
                    su_req.start = 1'b1;
                    su_req.a     = {32'd0, r_hvar};
                    su_req.b     = {16'd0, r_persist};
                    n_state      = S_HMUL;
                end
            end
            S_HMUL: begin
                if (su_rsp.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (can_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    logic [47:0] prod_shift;
    logic signed [33:0] ret_wide;
    logic signed [32:0] rsum_wide;
    logic [32:0] sq_wide;
    logic signed [41:0] h_fin;

    assign prod_shift = su_rsp.res[59:12];
    assign ret_wide   = (prod_shift[47:33] != 15'd0) ? 34'sh0_FFFF_FFFF
                        : $signed({1'b0, prod_shift[32:0]});
    assign rsum_wide  = $signed({r_rsum[31], r_rsum}) + $signed({r_ret[31], r_ret});
    assign sq_wide    = {1'b0, r_sqsum} + {1'b0, su_rsp.res[55:24]};
    assign h_fin      = $signed({r_hacc[40], r_hacc}) + $signed({2'b00, su_rsp.res[55:16]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_arch    <= '0;
            r_persist <= '0;
            r_asym    <= '0;
            r_h0      <= 32'h0100_0000;
            r_slots   <= 13'd1;
            r_hvar    <= '0;
            r_scale   <= '0;
            r_rsum    <= '0;
            r_sqsum   <= '0;
            r_slot    <= '0;
            r_first   <= 1'b1;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ARCH:    r_arch    <= i_cfg_data[15:0];
                    CFG_PERSIST: r_persist <= i_cfg_data[15:0];
                    CFG_ASYM:    r_asym    <= i_cfg_data[15:0];
                    CFG_H0:      r_h0      <= i_cfg_data;
                    CFG_SLOTS:   r_slots   <= i_cfg_data[12:0];
                    default:     ;
                endcase
            end
            if (r_state == S_OUT && n_state == S_IDLE) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_z    <= i_innovation;
                        r_last <= ({1'b0, r_slot} + 13'd1) >= eff_n;
                        if (r_slot == 12'd0 && r_first) begin
                            r_hvar  <= r_h0;
                            r_first <= 1'b0;
                        end
                    end
                end
                S_SQRT: begin
                    if (su_rsp.done) begin
                        r_scale <= su_rsp.res[31:0];
                    end
                end
                S_RMUL: begin
                    if (su_rsp.done) begin
                        if (ret_wide[32]) begin
                            r_ret <= r_z[15] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                        end else begin
                            r_ret <= r_z[15] ? 32'(-ret_wide[31:0]) : ret_wide[31:0];
                        end
                    end
                end
                S_SQMUL: begin
                    if (rsum_wide > 33'sd2147483647) begin
                        r_rsum <= 32'h7FFF_FFFF;
                    end else if (rsum_wide < -33'sd2147483648) begin
                        r_rsum <= 32'h8000_0000;
                    end else begin
                        r_rsum <= rsum_wide[31:0];
                    end
                end
                S_ACC: begin
                    if (su_rsp.done) begin
                        r_sqsum <= (sq_wide[32] || su_rsp.res[63:56] != 8'd0)
                                   ? 32'hFFFF_FFFF : sq_wide[31:0];
                        r_hacc  <= 41'sd16777216 - $signed({17'd0, r_arch, 8'd0})
                                   - $signed({17'd0, r_persist, 8'd0})
                                   - $signed({18'd0, r_asym, 7'd0});
                    end
                end
                S_BMUL: begin
                    if (su_rsp.done) begin
                        r_hacc <= 41'(h_fin);
                    end
                end
                S_OUT: begin
                    if (n_state == S_IDLE) begin
                        r_o_ret  <= r_ret;
                        r_o_end  <= r_last;
                        r_o_dret <= r_last ? r_rsum : 32'd0;
                        r_o_dvar <= r_last ? r_hvar : 32'd0;
                        r_o_rv   <= r_last ? r_sqsum : 32'd0;
                        if (r_last) begin
                            r_rsum  <= '0;
                            r_sqsum <= '0;
                            r_slot  <= '0;
                            if (h_fin < 0) begin
                                r_hvar <= '0;
                            end else if (h_fin > 42'sh0_FFFF_FFFF) begin
                                r_hvar <= 32'hFFFF_FFFF;
                            end else begin
                                r_hvar <= h_fin[31:0];
                            end
                        end else begin
                            r_slot <= r_slot + 12'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid             = r_ovalid;
    assign o_intraday_return   = r_o_ret;
    assign o_day_end           = r_o_end;
    assign o_daily_return      = r_o_dret;
    assign o_daily_variance    = r_o_dvar;
    assign o_realized_variance = r_o_rv;

endmodule

FILE: rtl/gjr_serial_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GJR-GARCH serial arithmetic unit
// Bit-serial unsigned multiply (64x32), divide (64/32) and integer square
// root (64-bit), one result bit per cycle.
// ----------------------------------------------------------------------------
module gjr_serial_unit
    import gjr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_su_req i_req,
    output t_su_rsp o_rsp
);

    logic        r_busy, n_busy;
    t_op         r_op, n_op;
    logic [6:0]  r_cnt, n_cnt;
    logic [63:0] r_acc, n_acc;
    logic [63:0] r_sh, n_sh;
    logic [65:0] r_rem, n_rem;
    logic [63:0] r_b, n_b;
    logic        r_done, n_done;
    logic [65:0] trial;
    logic [65:0] rem_sh;

    always_comb begin
        n_busy = r_busy;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_sh   = r_sh;
        n_rem  = r_rem;
        n_b    = r_b;
        n_done = 1'b0;
        rem_sh = '0;
        trial  = '0;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_op   = i_req.op;
            n_acc  = '0;
            n_rem  = '0;
            n_sh   = i_req.a;
            n_b    = {32'd0, i_req.b};
            n_cnt  = (i_req.op == OP_SQRT) ? 7'd32 : (i_req.op == OP_MUL) ? 7'd32 : 7'd64;
        end else if (r_busy) begin
            case (r_op)
                OP_MUL: begin
                    if (r_b[0]) begin
                        n_acc = r_acc + r_sh;
                    end
                    n_sh = {r_sh[62:0], 1'b0};
                    n_b  = {1'b0, r_b[63:1]};
                end
                OP_DIV: begin
                    rem_sh = {r_rem[64:0], r_sh[63]};
                    n_sh   = {r_sh[62:0], 1'b0};
                    if (rem_sh >= {2'd0, r_b}) begin
                        n_rem = rem_sh - {2'd0, r_b};
                        n_acc = {r_acc[62:0], 1'b1};
                    end else begin
                        n_rem = rem_sh;
                        n_acc = {r_acc[62:0], 1'b0};
                    end
                end
                OP_SQRT: begin
                    rem_sh = {r_rem[63:0], r_sh[63:62]};
                    n_sh   = {r_sh[61:0], 2'b00};
                    trial  = {r_acc[63:0], 2'b01};
                    if (rem_sh >= trial) begin
                        n_rem = rem_sh - trial;
                        n_acc = {r_acc[62:0], 1'b1};
                    end else begin
                        n_rem = rem_sh;
                        n_acc = {r_acc[62:0], 1'b0};
                    end
                end
                default: n_busy = 1'b0;
            endcase
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= OP_MUL;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_op   <= n_op;
            r_cnt  <= n_cnt;
        end
        r_acc <= n_acc;
        r_sh  <= n_sh;
        r_rem <= n_rem;
        r_b   <= n_b;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_acc;

endmodule

FILE: rtl/gjr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GJR-GARCH generator checker
// Port-level checks of the intraday return generator.
// ----------------------------------------------------------------------------
module gjr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_day_end,
    input logic [31:0] o_intraday_return,
    input logic [31:0] o_daily_return,
    input logic [31:0] o_daily_variance,
    input logic [31:0] o_realized_variance
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_intraday_return))
        else $error("result beat changed while stalled");

    a_mid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_day_end |-> o_daily_return == 32'd0 && o_daily_variance == 32'd0
        && o_realized_variance == 32'd0)
        else $error("daily fields nonzero on a mid-day beat");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind gjr_garch_intraday_return_generator gjr_checker u_chk (.*);

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Intraday return generator testbench
// Drives innovation beats with random gaps and back-pressure, predicts every
// result from its own model of the GJR-GARCH day cycle, and compares each
// result beat field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
    import gjr_pkg::*;

    typedef struct {
        logic [31:0] ret;
        logic        last;
        logic [31:0] dret;
        logic [31:0] dvar;
        logic [31:0] rvar;
    } t_day_result;

    int errors = 0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    class return_scoreboard;
        logic [15:0] alpha, beta, gamma, slots;
        logic [31:0] h0_reg;
        logic [31:0] var_h, scale, sq_sum;
        int          slot;
        logic signed [31:0] ret_sum;
        bit          first_day;
        t_day_result pending[$];

        function new();
            alpha = 0; beta = 0; gamma = 0; h0_reg = 32'h0100_0000; slots = 1;
            var_h = 0; scale = 0; sq_sum = 0; slot = 0; ret_sum = 0; first_day = 1;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [31:0] d);
            case (idx)
                CFG_ARCH:    alpha = d[15:0];
                CFG_PERSIST: beta = d[15:0];
                CFG_ASYM:    gamma = d[15:0];
                CFG_H0:      h0_reg = d;
                CFG_SLOTS:   slots = {3'b0, d[12:0]};
                default: ;
            endcase
        endfunction

        function logic [63:0] root(logic [63:0] v);
            logic [63:0] res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v -= res + b;
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        function longint sat32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function void note_innovation(logic [15:0] zin);
            longint n, z, zm, prod, r, sq, h, rm, r2, coef, tot;
            t_day_result e;
            n = (slots == 0) ? 1 : (slots > MaxSlots ? MaxSlots : slots);
            z = $signed(zin);
            if (slot == 0) begin
                if (first_day) begin
                    var_h = h0_reg;
                    first_day = 0;
                end
                scale = 32'(root(({32'b0, var_h} << 24) / n));
            end
            zm = z < 0 ? -z : z;
            prod = (zm * longint'({32'b0, scale})) >>> 12;
            r = sat32(z < 0 ? -prod : prod);
            ret_sum = 32'(sat32(longint'(ret_sum) + r));
            zm = r < 0 ? -r : r;
            sq = (64'(zm) * 64'(zm)) >> 24;
            tot = longint'({32'b0, sq_sum}) + sq;
            sq_sum = (tot > 64'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : tot[31:0];
            e.ret = r[31:0];
            e.last = (slot + 1) >= n;
            e.dret = 0; e.dvar = 0; e.rvar = 0;
            if (e.last) begin
                e.dret = ret_sum; e.dvar = var_h; e.rvar = sq_sum;
                rm = ret_sum < 0 ? -longint'(ret_sum) : ret_sum;
                r2 = (64'(rm) * 64'(rm)) >> 24;
                coef = alpha + ((ret_sum < 0) ? gamma : 0);
                h = 64'sd16777216 - (longint'(alpha) << 8) - (longint'(beta) << 8)
                    - (longint'(gamma) << 7);
                h += (64'(coef) * 64'(r2)) >> 16;
                h += (longint'(beta) * longint'({32'b0, var_h})) >>> 16;
                if (h < 0) h = 0;
                var_h = (h > 64'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : h[31:0];
                ret_sum = 0; sq_sum = 0; slot = 0;
            end else begin
                slot = (slot + 1) & 12'hFFF;
            end
            pending.push_back(e);
        endfunction

        task check_result(logic [31:0] r, logic l, logic [31:0] dr,
                          logic [31:0] dv, logic [31:0] rv);
            t_day_result e;
            if (pending.size() == 0) begin
                report("unexpected beat", r, 0);
                return;
            end
            e = pending.pop_front();
            if (r !== e.ret) report("intraday_return", r, e.ret);
            if (l !== e.last) report("day_end", l, e.last);
            if (dr !== e.dret) report("daily_return", dr, e.dret);
            if (dv !== e.dvar) report("daily_variance", dv, e.dvar);
            if (rv !== e.rvar) report("realized_variance", rv, e.rvar);
        endtask
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [2:0]  cfg_idx = 0;
    logic [31:0] cfg_data = 0;
    logic        in_valid = 0;
    logic        in_ready;
    logic [15:0] innovation = 0;
    logic        out_valid;
    logic        out_ready = 0;
    logic [31:0] o_ret, o_dret, o_dvar, o_rvar;
    logic        o_end;

    return_scoreboard sb = new();
    int   idle_pct = 27;
    logic hold = 0;
    event hold_go;

    gjr_garch_intraday_return_generator u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_ready(in_ready), .i_innovation(innovation),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_intraday_return(o_ret), .o_day_end(o_end), .o_daily_return(o_dret),
        .o_daily_variance(o_dvar), .o_realized_variance(o_rvar)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #50_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        @(hold_go);
        hold <= 1'b1;
        repeat (3000) @(posedge clk);
        hold <= 1'b0;
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(o_ret, o_end, o_dret, o_dvar, o_rvar);
        if (hold) begin
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] d);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= d;
        sb.write_reg(idx, d);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_beat(input logic [15:0] z);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        innovation <= z;
        do @(posedge clk); while (!in_ready);
        sb.note_innovation(z);
    endtask

    task automatic drain();
        int guard;
        in_valid <= 1'b0;
        guard = 0;
        while (sb.pending.size() != 0 && guard < 200000) begin
            @(posedge clk);
            guard++;
        end
        if (sb.pending.size() != 0)
            report("missing beats", 32'(sb.pending.size()), 32'd0);
        repeat (300) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_z();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(16'hFFFF));
            default: return 16'($signed($urandom_range(8192)) - 4096);
        endcase
    endfunction

    task automatic random_phase(input int count, input logic [31:0] a, b, g, n);
        write_reg(CFG_ARCH, a);
        write_reg(CFG_PERSIST, b);
        write_reg(CFG_ASYM, g);
        write_reg(CFG_SLOTS, n);
        repeat (count) send_beat(rand_z());
        drain();
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(CFG_H0, 32'h0200_0000);
        write_reg(CFG_SLOTS, 3);
        send_beat(16'h7FFF);
        send_beat(16'h8000);
        send_beat(16'h0000);
        send_beat(16'hFFFF);
        send_beat(16'h0001);
        send_beat(16'h8000);
        drain();
        // Initial variance is only taken once, so this write must not matter.
        write_reg(CFG_H0, 32'hFFFF_FFFF);
        write_reg(CFG_ARCH, 16'hFFFF);
        write_reg(CFG_PERSIST, 16'hFFFF);
        write_reg(CFG_ASYM, 16'hFFFF);
        write_reg(CFG_SLOTS, 0);
        send_beat(16'h8000);
        send_beat(16'h7FFF);
        drain();
        write_reg(CFG_SLOTS, 13'h1FFF);
        send_beat(16'h0800);
        drain();
        write_reg(CFG_SLOTS, 5);
        send_beat(16'h1000);
        send_beat(16'h1000);
        send_beat(16'h1000);
        drain();
        // Lowering the slot count mid-day ends the current day with the next beat.
        write_reg(CFG_SLOTS, 2);
        send_beat(16'hF000);
        drain();
        write_reg(CFG_SLOTS, 1);
        repeat (4) send_beat(16'h8000);
        drain();

        random_phase(150, 3277, 58982, 6554, 4);
        idle_pct = 0;
        random_phase(100, $urandom_range(16'hFFFF), $urandom_range(16'hFFFF),
                     $urandom_range(16'hFFFF), 1);
        idle_pct = 27;
        -> hold_go;
        random_phase(150, 6554, 52429, 13107, $urandom_range(2, 9));
        random_phase(150, $urandom_range(16'hFFFF), $urandom_range(16'hFFFF),
                     $urandom_range(16'hFFFF), $urandom_range(1, 20));
        random_phase(40, 1000, 60000, 3000, 4096);

        if (errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end
endmodule
